@@ src/rtpmv_pkg.sv @@
// shared types and constants of the rtp mpeg video packetizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rtpmv_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int PTS_W  = 48;
  localparam int PS_W   = 12;
  localparam int SEQ_W  = 16;
  localparam int TS_W   = 32;

  // rtp header constants
  localparam logic [7:0] RTP_VERSION   = 8'h80;
  localparam logic [7:0] PT_MPEG_VIDEO = 8'd32;
  localparam logic [7:0] MARKER_BIT    = 8'h80;
  localparam logic [7:0] SEQ_START_BIT = 8'h20;
  localparam logic [7:0] SEQ_HDR_CODE  = 8'hB3;
  localparam logic [7:0] START_CODE_LO = 8'h01;
  localparam int         HDR_LEN       = 16;

  // payload size register
  localparam logic [PS_W-1:0] PS_RESET = 12'd1456;
  localparam logic [PS_W-1:0] PS_MIN   = 12'd4;
  localparam int              PS_LIMIT = 4095;

  // timestamp divider: (pts * 9 + 50) / 100, four quotient bits a step
  localparam int DIV_W      = PTS_W + 4;
  localparam int DIV_RADIX  = 4;
  localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam logic [7:0] DIV_DIVISOR = 8'd100;
  localparam logic [DIV_W-1:0] DIV_ROUND = DIV_W'(50);

  // command queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic [LEN_W-1:0]  unit_length;
    logic [PTS_W-1:0]  pts_us;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              packet_last;
    logic              run_last;
  } out_item_t;

  // one command per accepted input byte that produces output
  typedef struct packed {
    logic                   hdr;        // emit a 16-byte header first
    logic                   marker;
    logic                   seq_flag;
    logic [SEQ_W-1:0]       seq;
    logic [TS_W-1:0]        ts;
    logic                   four;       // four payload bytes instead of one
    logic [3:0][BYTE_W-1:0] bytes;      // bytes[0] leaves first
    logic                   last_byte;  // final payload byte closes the packet
  } cmd_t;

endpackage

`default_nettype wire

@@ src/rtp_mpeg_video_packetizer_unit.sv @@
// top level of the rtp mpeg video packetizer
// depends on rtpmv_pkg, rtpmv_front, rtpmv_fifo and rtpmv_back
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel (in_valid / in_ready / in_data): one byte of an access unit per
//   transaction; unit_length and pts_us are sampled with the unit's first byte only
//   output channel (out_valid / out_ready / out_data): one packet byte per transaction,
//   16 header bytes then payload; packet_last marks the end of a packet and run_last
//   the last byte produced by one input byte
//   cfg_wr_en / cfg_wr_data: payload_size register, written only while idle (the user's
//   duty, not enforced); values below 4 act as 4, above MAX_PAYLOAD as MAX_PAYLOAD
// flow
//   an accepted byte passes the queue, then the output register, on its way out
//   a payload byte yields one output byte, a packet start 17, the fourth byte 20;
//   the output port sets the rate, one byte a cycle while out_ready is high: input
//   runs at one byte per cycle inside a packet and is held off while headers drain
//   the 90 khz timestamp comes from a divider started by the unit's first byte; the
//   fourth byte, or a byte opening a later packet, waits while the divider is busy
// reset and stalls
//   rst (synchronous) empties the queue, clears the sequence number and sets
//   payload_size to 1456; when out_ready is low the output holds and the two-entry
//   queue fills, then in_ready drops until the receiver takes data again
module rtp_mpeg_video_packetizer_unit #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  rtpmv_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output rtpmv_pkg::out_item_t         out_data,
  input  wire                          cfg_wr_en,
  input  wire [rtpmv_pkg::PS_W-1:0]    cfg_wr_data
);
  import rtpmv_pkg::*;

  logic [PS_W-1:0] payload_size;

  // command queue wiring
  logic q_push, q_not_full, q_pop, q_not_empty;
  cmd_t q_in, q_head;

  // payload size register
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_size <= PS_RESET;
    end else if (cfg_wr_en) begin
      payload_size <= cfg_wr_data;
    end
  end

  // front: start code check, chunking, sequence numbers, timestamp
  rtpmv_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .payload_size (payload_size),
    .q_ready      (q_not_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // decouples classification from byte serialization
  rtpmv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: header and payload bytes out through the output register
  rtpmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ src/rtpmv_ts_div.sv @@
// iterative divider turning microsecond pts into the 90 khz rtp timestamp
// depends on rtpmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtpmv_ts_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [rtpmv_pkg::PTS_W-1:0]   pts,
  output logic                         busy,
  output logic [rtpmv_pkg::TS_W-1:0]   ts
);
  import rtpmv_pkg::*;

  logic [DIV_W-1:0]     dvd;
  logic [6:0]           rem;
  logic [DIV_CNT_W-1:0] steps;
  logic [6:0]           rem_next;
  logic [TS_W-1:0]      ts_next;

  // four restoring steps per cycle on a remainder below 100
  always_comb begin
    logic [7:0] trial;
    rem_next = rem;
    ts_next  = ts;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_next, dvd[DIV_W-1-i]};
      if (trial >= DIV_DIVISOR) begin
        rem_next = 7'(trial - DIV_DIVISOR);
        ts_next  = {ts_next[TS_W-2:0], 1'b1};
      end else begin
        rem_next = trial[6:0];
        ts_next  = {ts_next[TS_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      steps <= steps - 1'b1;
      busy  <= (steps != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {pts, 3'b000} + {4'b0000, pts} + DIV_ROUND;
      rem <= '0;
      ts  <= '0;
    end else if (busy) begin
      dvd <= dvd << DIV_RADIX;
      rem <= rem_next;
      ts  <= ts_next;
    end
  end

endmodule

`default_nettype wire

@@ src/rtpmv_front.sv @@
// front end: accepts unit bytes, checks the start code, cuts chunks, builds commands
// depends on rtpmv_pkg and rtpmv_ts_div
`timescale 1ns / 1ps
`default_nettype none

module rtpmv_front #(
  parameter int MAX_PAYLOAD = 2048
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  rtpmv_pkg::in_item_t         in_data,
  input  wire [rtpmv_pkg::PS_W-1:0]   payload_size,
  input  wire                         q_ready,
  output logic                        q_push,
  output rtpmv_pkg::cmd_t             q_data
);
  import rtpmv_pkg::*;

  localparam int PsCap = (MAX_PAYLOAD > PS_LIMIT) ? PS_LIMIT : MAX_PAYLOAD;
  localparam logic [PS_W-1:0] PS_CAP = PS_W'(PsCap);

  logic [LEN_W-1:0]       unit_rem, unit_rem_next;
  logic [PS_W-1:0]        chunk_rem, chunk_rem_next;
  logic [2:0]             head_count, head_count_next;
  logic [3:0][BYTE_W-1:0] head_bytes, head_bytes_next;
  logic                   dropping, dropping_next;
  logic [SEQ_W-1:0]       seq, seq_next;

  logic             div_start, div_busy;
  logic [TS_W-1:0]  ts;

  logic             starting, drop, stall_hdr, first_hdr;
  logic [LEN_W-1:0] rem, hrem;
  logic [2:0]       hc;
  logic [PS_W-1:0]  ps, size;
  logic             marker;

  rtpmv_ts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .pts   (in_data.pts_us),
    .busy  (div_busy),
    .ts    (ts)
  );

  // effective payload size
  always_comb begin
    if (payload_size < PS_MIN) begin
      ps = PS_MIN;
    end else if (payload_size > PS_CAP) begin
      ps = PS_CAP;
    end else begin
      ps = payload_size;
    end
  end

  assign starting  = (unit_rem == '0);
  assign rem       = starting ? in_data.unit_length : unit_rem;
  assign drop      = starting ? (in_data.unit_length < LEN_W'(4)) : dropping;
  assign hc        = starting ? 3'd0 : head_count;
  assign first_hdr = (hc == 3'd3);
  // the fourth byte's header covers the whole unit
  assign hrem      = first_hdr ? (rem + LEN_W'(3)) : rem;
  assign size      = (hrem < LEN_W'(ps)) ? hrem[PS_W-1:0] : ps;
  assign marker    = (hrem <= LEN_W'(ps));

  // a header needs the timestamp of the running unit
  assign stall_hdr = !starting && !dropping && div_busy &&
                     ((head_count == 3'd3) || ((head_count == 3'd4) && (chunk_rem == '0)));
  assign in_ready  = q_ready && !stall_hdr;

  always_comb begin
    unit_rem_next   = unit_rem;
    chunk_rem_next  = chunk_rem;
    head_count_next = head_count;
    head_bytes_next = head_bytes;
    dropping_next   = dropping;
    seq_next        = seq;
    div_start       = 1'b0;
    q_push          = 1'b0;
    q_data          = '0;
    q_data.ts       = ts;
    q_data.seq      = seq;
    q_data.marker   = marker;
    q_data.bytes[0] = in_data.in_byte;

    if (in_valid && in_ready && !(starting && (in_data.unit_length == '0))) begin
      if (starting) begin
        div_start      = 1'b1;
        chunk_rem_next = '0;
      end
      unit_rem_next   = rem - 1'b1;
      dropping_next   = drop;
      head_count_next = hc;
      if (!drop) begin
        if (hc < 3'd4) begin
          head_count_next = hc + 1'b1;
          head_bytes_next[hc[1:0]] = in_data.in_byte;
          if (first_hdr) begin
            if ((head_bytes[0] != '0) || (head_bytes[1] != '0) ||
                (head_bytes[2] != START_CODE_LO)) begin
              dropping_next = 1'b1;
            end else begin
              q_push            = 1'b1;
              q_data.hdr        = 1'b1;
              q_data.seq_flag   = (in_data.in_byte == SEQ_HDR_CODE);
              q_data.four       = 1'b1;
              q_data.bytes[0]   = head_bytes[0];
              q_data.bytes[1]   = head_bytes[1];
              q_data.bytes[2]   = head_bytes[2];
              q_data.bytes[3]   = in_data.in_byte;
              q_data.last_byte  = (size == PS_W'(4));
              chunk_rem_next    = size - PS_W'(4);
              seq_next          = seq + 1'b1;
            end
          end
        end else begin
          q_push = 1'b1;
          if (chunk_rem == '0) begin
            q_data.hdr       = 1'b1;
            q_data.last_byte = (size == PS_W'(1));
            chunk_rem_next   = size - 1'b1;
            seq_next         = seq + 1'b1;
          end else begin
            q_data.last_byte = (chunk_rem == PS_W'(1));
            chunk_rem_next   = chunk_rem - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_rem   <= '0;
      chunk_rem  <= '0;
      head_count <= '0;
      head_bytes <= '0;
      dropping   <= 1'b0;
      seq        <= '0;
    end else begin
      unit_rem   <= unit_rem_next;
      chunk_rem  <= chunk_rem_next;
      head_count <= head_count_next;
      head_bytes <= head_bytes_next;
      dropping   <= dropping_next;
      seq        <= seq_next;
    end
  end

endmodule

`default_nettype wire

@@ src/rtpmv_fifo.sv @@
// two-entry command queue between front and back
// depends on rtpmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtpmv_fifo (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  rtpmv_pkg::cmd_t   push_data,
  output logic              not_full,
  input  wire               pop,
  output logic              not_empty,
  output rtpmv_pkg::cmd_t   head
);
  import rtpmv_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t               slots [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;

  assign not_full  = (count != (PTR_W+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/rtpmv_back.sv @@
// back end: serializes one command into header and payload bytes
// depends on rtpmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtpmv_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cmd_valid,
  input  rtpmv_pkg::cmd_t       cmd,
  output logic                  cmd_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output rtpmv_pkg::out_item_t  out_data
);
  import rtpmv_pkg::*;

  logic [4:0]        pos;
  logic [4:0]        hdr_len, last_pos;
  logic [4:0]        pay_pos;
  logic              in_hdr, is_last, load;
  logic [BYTE_W-1:0] hdr_byte, cur_byte;

  assign hdr_len  = cmd.hdr ? 5'(HDR_LEN) : 5'd0;
  assign last_pos = hdr_len + (cmd.four ? 5'd3 : 5'd0);
  assign in_hdr   = cmd.hdr && (pos < 5'(HDR_LEN));
  assign pay_pos  = pos - hdr_len;
  assign is_last  = (pos == last_pos);
  assign load     = cmd_valid && (!out_valid || out_ready);
  assign cmd_pop  = load && is_last;

  always_comb begin
    case (pos[3:0])
      4'd0:    hdr_byte = RTP_VERSION;
      4'd1:    hdr_byte = PT_MPEG_VIDEO | (cmd.marker ? MARKER_BIT : 8'h00);
      4'd2:    hdr_byte = cmd.seq[15:8];
      4'd3:    hdr_byte = cmd.seq[7:0];
      4'd4:    hdr_byte = cmd.ts[31:24];
      4'd5:    hdr_byte = cmd.ts[23:16];
      4'd6:    hdr_byte = cmd.ts[15:8];
      4'd7:    hdr_byte = cmd.ts[7:0];
      4'd14:   hdr_byte = cmd.seq_flag ? SEQ_START_BIT : 8'h00;
      default: hdr_byte = 8'h00;
    endcase
  end

  assign cur_byte = in_hdr ? hdr_byte : cmd.bytes[pay_pos[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= is_last ? 5'd0 : pos + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte    <= cur_byte;
      out_data.packet_last <= is_last && cmd.last_byte;
      out_data.run_last    <= is_last;
    end
  end

endmodule

`default_nettype wire

@@ src/rtpmv_checker.sv @@
// port-level checks of the packetizer output stream, bound to the top level
// depends on rtpmv_pkg and rtp_mpeg_video_packetizer_unit
`timescale 1ns / 1ps
`default_nettype none

module rtpmv_checker (
  input wire                     clk,
  input wire                     rst,
  input wire                     out_valid,
  input wire                     out_ready,
  input rtpmv_pkg::out_item_t    out_data
);
  import rtpmv_pkg::*;

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // the end of a packet is always the end of a run
  a_pkt_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.packet_last |-> out_data.run_last)
    else $error("packet ended inside a run");

  // the byte after a packet end opens a new header
  a_new_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.packet_last |=>
      !out_valid || (out_data.out_byte == RTP_VERSION))
    else $error("packet not followed by a header");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rtp_mpeg_video_packetizer_unit rtpmv_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/rtp_mpeg_video_packetizer_unit_tb.sv @@
// self-checking testbench for the rtp mpeg video packetizer top level
// depends on rtpmv_pkg and rtp_mpeg_video_packetizer_unit; needs nothing else
`timescale 1ns / 1ps

module rtp_mpeg_video_packetizer_unit_tb;
  import rtpmv_pkg::*;

  localparam int MAX_PAYLOAD   = 2048;
  // queue, output register and the timestamp divider, with margin
  localparam int SETTLE_CYCLES = 32;
  localparam int RX_HOLD_LEN   = 400;

  // predicts the packet byte stream from the accepted video bytes and
  // checks every output transaction against it in order
  class packet_byte_predictor;
    logic [PS_W-1:0]  payload_reg;
    logic [SEQ_W-1:0] seq_num;
    int unsigned      unit_left;
    int unsigned      chunk_left;
    logic [7:0]       held [4];
    int unsigned      held_cnt;
    logic [TS_W-1:0]  ts90k;
    bit               first_pkt;
    bit               seq_start;
    bit               dropping;
    out_item_t        step_bytes [$];
    out_item_t        expected_packet_bytes [$];
    int unsigned      accepted, checked, packets, units, dropped, errors;

    function new();
      payload_reg = PS_RESET;
      seq_num     = '0;
      unit_left   = 0;
      chunk_left  = 0;
      foreach (held[i]) held[i] = '0;
      held_cnt    = 0;
      ts90k       = '0;
      first_pkt   = 0;
      seq_start   = 0;
      dropping    = 0;
      accepted    = 0;
      checked     = 0;
      packets     = 0;
      units       = 0;
      dropped     = 0;
      errors      = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic last);
      out_item_t ob;
      ob.out_byte    = b;
      ob.packet_last = last;
      ob.run_last    = 1'b0;
      step_bytes.push_back(ob);
    endfunction

    // 16-byte header; opens a chunk of at most the clamped payload size
    function void add_rtp_header(int unsigned rem);
      int unsigned ps;
      int unsigned size;
      bit          marker;
      ps = payload_reg;
      if (ps < PS_MIN) ps = PS_MIN;
      if (ps > MAX_PAYLOAD) ps = MAX_PAYLOAD;
      size   = (rem < ps) ? rem : ps;
      marker = (rem <= ps);
      push_byte(RTP_VERSION, 1'b0);
      push_byte(PT_MPEG_VIDEO | (marker ? MARKER_BIT : 8'h00), 1'b0);
      push_byte(seq_num[15:8], 1'b0);
      push_byte(seq_num[7:0], 1'b0);
      push_byte(ts90k[31:24], 1'b0);
      push_byte(ts90k[23:16], 1'b0);
      push_byte(ts90k[15:8], 1'b0);
      push_byte(ts90k[7:0], 1'b0);
      // source id and the two upper flag bytes
      repeat (6) push_byte(8'h00, 1'b0);
      push_byte((first_pkt && seq_start) ? SEQ_START_BIT : 8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      chunk_left = size;
      seq_num    = seq_num + 1'b1;
      first_pkt  = 0;
    endfunction

    function void add_payload_byte(logic [7:0] b);
      if (chunk_left > 0) chunk_left--;
      push_byte(b, chunk_left == 0);
    endfunction

    function void note_video_byte(in_item_t it);
      int unsigned rem;
      logic [63:0] scaled;
      out_item_t   ob;
      accepted++;
      step_bytes.delete();
      if (unit_left == 0) begin
        if (it.unit_length == '0) return;
        unit_left  = it.unit_length;
        scaled     = ({16'd0, it.pts_us} * 64'd9 + 64'd50) / 64'd100;
        ts90k      = scaled[31:0];
        held_cnt   = 0;
        chunk_left = 0;
        dropping   = (it.unit_length < 4);
        first_pkt  = 0;
        seq_start  = 0;
        units++;
        if (dropping) dropped++;
      end
      rem = unit_left;
      unit_left--;
      if (dropping) return;
      if (held_cnt < 4) begin
        held[held_cnt] = it.in_byte;
        held_cnt++;
        if (held_cnt < 4) return;
        if (held[0] != 8'h00 || held[1] != 8'h00 || held[2] != START_CODE_LO) begin
          dropping = 1;
          dropped++;
          return;
        end
        seq_start = (held[3] == SEQ_HDR_CODE);
        first_pkt = 1;
        add_rtp_header(rem + 3);
        for (int i = 0; i < 4; i++) add_payload_byte(held[i]);
      end else begin
        if (chunk_left == 0) add_rtp_header(rem);
        add_payload_byte(it.in_byte);
      end
      for (int i = 0; i < step_bytes.size(); i++) begin
        ob          = step_bytes[i];
        ob.run_last = (i == step_bytes.size() - 1);
        expected_packet_bytes.push_back(ob);
      end
    endfunction

    function void check_packet_byte(out_item_t got);
      out_item_t want;
      if (expected_packet_bytes.size() == 0) begin
        errors++;
        $display("%0t: output transaction with nothing expected, actual %02h/%b/%b",
                 $time, got.out_byte, got.packet_last, got.run_last);
        return;
      end
      want = expected_packet_bytes.pop_front();
      checked++;
      if (want.packet_last) packets++;
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %02h actual %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.packet_last !== want.packet_last) begin
        errors++;
        $display("%0t: packet_last expected %b actual %b",
                 $time, want.packet_last, got.packet_last);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: run_last expected %b actual %b",
                 $time, want.run_last, got.run_last);
      end
    endfunction
  endclass

  // every input starts at a known value; reset is high from time zero
  logic            clk         = 1'b0;
  logic            rst         = 1'b1;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  in_item_t        in_data     = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  out_item_t       out_data;
  logic            cfg_wr_en   = 1'b0;
  logic [PS_W-1:0] cfg_wr_data = '0;

  packet_byte_predictor sb;

  // idling switches and the long receiver hold-off request
  bit          tx_idle        = 1'b1;
  bit          rx_idle        = 1'b1;
  int          rx_hold_cycles = 0;
  int unsigned cfg_writes     = 0;

  rtp_mpeg_video_packetizer_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // both channels sampled at the rising edge; all drivers use nonblocking
  // assignments, so the values read here are the ones the dut saw
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_video_byte(in_data);
      if (out_valid && out_ready) sb.check_packet_byte(out_data);
    end
  end

  // receiver: ready stretches broken by random gaps, or always ready when
  // idling is off; a hold-off request keeps ready low for the whole count
  initial begin
    int gap;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (!rx_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // one input transaction; valid stays up into the next call when no gap follows
  task automatic send_video_byte(logic [7:0] b, logic [LEN_W-1:0] len,
                                 logic [PTS_W-1:0] pts);
    int gap;
    in_valid <= 1'b1;
    in_data  <= {b, len, pts};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tx_idle) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // whole access unit: head holds the first four bytes, msb first, the rest
  // are random; length and pts ride on the first byte, the other bytes carry
  // random values there that the block must ignore
  task automatic send_unit(int unsigned len, logic [PTS_W-1:0] pts, logic [31:0] head);
    logic [7:0] b;
    for (int unsigned k = 0; k < len; k++) begin
      if (k < 4) b = head[31 - 8*k -: 8];
      else b = $urandom;
      if (k == 0) send_video_byte(b, len[LEN_W-1:0], pts);
      else send_video_byte(b, $urandom, {$urandom, $urandom});
    end
  endtask

  // sender rests until every predicted byte is out, then lets the divider
  // and pipeline settle so that bytes with no output are finished too
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (sb.expected_packet_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_payload_size(logic [PS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.payload_reg = v;
    cfg_writes++;
  endtask

  // random units until about target_items bytes went out: mostly well-formed
  // units, with start-code near misses, short units and zero-length bytes mixed in
  task automatic run_random_phase(int unsigned target_items);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [31:0] head;
    logic [PTS_W-1:0] pts;
    sent = 0;
    while (sent < target_items) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) pts = {$urandom, $urandom};
      else pts = $urandom_range(0, 100000);
      head[31:8] = 24'h000001;
      head[7:0]  = $urandom;
      if ($urandom_range(0, 3) == 0) head[7:0] = SEQ_HDR_CODE;
      if (r < 70) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(41, 300);
        else len = $urandom_range(4, 40);
      end else if (r < 82) begin
        // one wrong bit somewhere in the start code
        len = $urandom_range(4, 24);
        head[31:8] = head[31:8] ^ (24'd1 << $urandom_range(0, 23));
      end else if (r < 92) begin
        len = $urandom_range(1, 3);
      end else begin
        len = 0;
      end
      if (len == 0) begin
        send_video_byte($urandom, '0, pts);
      end else begin
        send_unit(len, pts, head);
        sent += len;
      end
    end
  endtask

  initial begin
    logic [PS_W-1:0] phase_sizes [7];
    sb = new();
    phase_sizes[0] = 12'd0;       // below the floor, acts as 4
    phase_sizes[1] = 12'd3;
    phase_sizes[2] = 12'd2049;    // just past the ceiling
    phase_sizes[3] = PS_MIN;
    phase_sizes[4] = MAX_PAYLOAD;
    phase_sizes[5] = $urandom_range(4, 64);
    phase_sizes[6] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset payload size
    // zero length byte is ignored, the block keeps waiting for a unit
    send_video_byte(8'hFF, '0, '1);
    // units shorter than four bytes vanish
    send_unit(1, 48'd1000, 32'h000001B3);
    send_unit(3, 48'd1000, 32'h000001B3);
    // bad start code drops the whole unit
    send_unit(5, 48'd7, 32'h000002B3);
    // shortest good unit, sequence header flag, timestamp tie rounds up (4.5 -> 5)
    send_unit(4, 48'd50, 32'h000001B3);

    // payload size changed mid-chunk: the running chunk keeps size 5
    wait_for_idle();
    write_payload_size(12'd5);
    send_video_byte(8'h00, 16'd9, '1);
    send_video_byte(8'h00, $urandom, {$urandom, $urandom});
    send_video_byte(START_CODE_LO, $urandom, {$urandom, $urandom});
    send_video_byte(8'hFF, $urandom, {$urandom, $urandom});
    wait_for_idle();
    write_payload_size(PS_MIN);
    send_video_byte(8'hFF, $urandom, {$urandom, $urandom});
    repeat (4) send_video_byte($urandom, $urandom, {$urandom, $urandom});

    // back-pressure: receiver stalls long while the sender keeps offering,
    // so the queue fills and in_ready drops
    wait_for_idle();
    write_payload_size(12'd16);
    rx_hold_cycles = RX_HOLD_LEN;
    send_unit(60, {$urandom, $urandom}, 32'h000001B3);

    // random phases across payload sizes and idling patterns
    for (int p = 0; p < 7; p++) begin
      wait_for_idle();
      write_payload_size(phase_sizes[p]);
      tx_idle = (p % 3 != 2);
      rx_idle = (p % 3 != 1);
      run_random_phase(18);
    end

    // longest unit at the largest register value, no idling on either side
    wait_for_idle();
    write_payload_size(12'hFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_unit(65535, {$urandom, $urandom}, 32'h00000100);

    wait_for_idle();
    $display("run covered %0d input bytes in %0d units (%0d dropped) and %0d output bytes",
             sb.accepted, sb.units, sb.dropped, sb.checked);
    $display("%0d packets over %0d payload size writes, one %0d-cycle receiver hold-off",
             sb.packets, cfg_writes, RX_HOLD_LEN);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout with %0d output bytes still expected",
             sb.expected_packet_bytes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
